/* rtl/pra_pkg.sv */
package pra_pkg;

    typedef enum logic [1:0] {
        OP_ALLOCATE = 2'd0,
        OP_CHECK    = 2'd1,
        OP_INIT     = 2'd2,
        OP_NONE     = 2'd3
    } pra_op_t;

    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [31:0] addr;
    } pra_token_t;

    typedef struct packed {
        logic        en;
        logic        clear;
        logic [31:0] first;
        logic [31:0] last;
    } pra_write_t;

endpackage

/* rtl/pra_cell.sv */
module pra_cell #(
    parameter int IDX_W = 9,
    parameter int IDX   = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pra_pkg::pra_write_t wr,
    input  logic [IDX_W-1:0]   wr_index,
    input  pra_pkg::pra_token_t tok_in,
    output pra_pkg::pra_token_t tok_out
);
    import pra_pkg::*;

    logic [31:0] first_reg;
    logic [31:0] last_reg;
    logic        valid_reg;
    pra_token_t  tok_reg;
    pra_token_t  tok_next;
    logic        sel;

    assign sel = wr.en && (wr_index == IDX_W'(IDX));

    always_comb
    begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | (valid_reg && (tok_in.addr >= first_reg)
                                    && (tok_in.addr < last_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel)
                valid_reg <= 1'b1;
            else if (wr.clear)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            first_reg <= wr.first;
            last_reg  <= wr.last;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* rtl/pra_chain.sv */
module pra_chain #(
    parameter int ENTRIES = 512,
    parameter int IDX_W   = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pra_pkg::pra_write_t wr,
    input  logic [IDX_W-1:0]   wr_index,
    input  pra_pkg::pra_token_t tok_in,
    output pra_pkg::pra_token_t tok_out
);
    import pra_pkg::*;

    pra_token_t tok [ENTRIES+1];

    assign tok[0] = tok_in;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        pra_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr       (wr),
            .wr_index (wr_index),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign tok_out = tok[ENTRIES];

endmodule

/* rtl/page_region_allocator_checker.sv */
// output: allocate, initialize and unused codes give their word in the cycle after acceptance
// output: a check inside the pool walks the allocated-region chain before its word is given
// flow: one word per cycle for words that skip the walk, while out_ready keeps the output free;
// no new word is taken during a walk, whose length the chain of cells (one stage per table entry) sets
// reset: asynchronous active low, clears tables' valid bits, counts and registers
module page_region_allocator_checker #(
    parameter int PAGE_BYTES    = 4096,
    parameter int TABLE_ENTRIES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] request_bytes,
    input  logic [31:0] query_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] region_start,
    output logic        granted,
    output logic        legitimate
);
    import pra_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
    localparam logic [32:0] RESERVE = 33'(2 * PAGE_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] base_reg, bytes_reg;
    logic [31:0] ffirst_reg, flast_reg;
    logic        fvalid_reg;
    logic [CNT_W-1:0] used_count_reg;
    logic        out_valid_reg;
    logic [31:0] region_start_reg;
    logic        granted_reg, legitimate_reg;

    pra_write_t  wr;
    logic [IDX_W-1:0] wr_index;
    pra_token_t  tok_in, tok_out;

    logic        accept;
    logic        out_free;
    logic [32:0] pages;
    logic [31:0] avail;
    logic [31:0] cut;
    logic        fit, full;
    logic [32:0] a33, base33, rsv_end, pool_end;
    logic        in_rsv, in_pool;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    assign pages = ({1'b0, request_bytes} + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
    assign avail = (flast_reg >= ffirst_reg) ? ((flast_reg - ffirst_reg) >> PAGE_SHIFT) : '0;
    assign cut   = 32'(pages << PAGE_SHIFT);
    assign fit   = fvalid_reg && ({1'b0, avail} > pages);
    assign full  = used_count_reg == CNT_W'(TABLE_ENTRIES);

    assign a33      = {1'b0, query_address};
    assign base33   = {1'b0, base_reg};
    assign rsv_end  = base33 + RESERVE;
    assign pool_end = base33 + {1'b0, bytes_reg};
    assign in_rsv   = (a33 >= base33) && (a33 < rsv_end);
    assign in_pool  = (a33 >= rsv_end) && (a33 < pool_end);

    always_comb
    begin
        wr       = '0;
        wr_index = used_count_reg[IDX_W-1:0];
        tok_in   = '0;
        tok_in.addr = query_address;
        if (accept)
        begin
            unique case (pra_op_t'(operation))
                OP_ALLOCATE:
                begin
                    wr.en    = fit && !full;
                    wr.first = ffirst_reg;
                    wr.last  = ffirst_reg + cut - 32'd1;
                end
                OP_CHECK:
                    tok_in.valid = !in_rsv && in_pool;
                OP_INIT:
                begin
                    wr.en    = 1'b1;
                    wr.clear = 1'b1;
                    wr_index = '0;
                    wr.first = base_reg;
                    wr.last  = base_reg + RESERVE[31:0] - 32'd1;
                end
                default: ;
            endcase
        end
    end

    pra_chain #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .wr_index (wr_index),
        .tok_in   (tok_in),
        .tok_out  (tok_out)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (tok_in.valid) state_next = ST_WALK;
            ST_WALK: if (tok_out.valid) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            base_reg         <= '0;
            bytes_reg        <= '0;
            fvalid_reg       <= 1'b0;
            used_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
            region_start_reg <= '0;
            granted_reg      <= 1'b0;
            legitimate_reg   <= 1'b0;
            ffirst_reg       <= '0;
            flast_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                    base_reg <= cfg_data;
                else
                    bytes_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (tok_out.valid)
            begin
                out_valid_reg    <= 1'b1;
                region_start_reg <= '0;
                granted_reg      <= 1'b0;
                legitimate_reg   <= tok_out.hit;
            end
            if (accept)
            begin
                region_start_reg <= '0;
                granted_reg      <= 1'b0;
                legitimate_reg   <= 1'b0;
                out_valid_reg    <= !tok_in.valid;
                unique case (pra_op_t'(operation))
                    OP_ALLOCATE:
                    begin
                        if (fit && !full)
                        begin
                            region_start_reg <= ffirst_reg;
                            granted_reg      <= 1'b1;
                            ffirst_reg       <= ffirst_reg + cut;
                            used_count_reg   <= used_count_reg + CNT_W'(1);
                        end
                    end
                    OP_CHECK:
                        legitimate_reg <= in_rsv;
                    OP_INIT:
                    begin
                        ffirst_reg     <= base_reg + RESERVE[31:0];
                        flast_reg      <= base_reg + bytes_reg - 32'd1;
                        fvalid_reg     <= 1'b1;
                        used_count_reg <= CNT_W'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign region_start = region_start_reg;
    assign granted      = granted_reg;
    assign legitimate   = legitimate_reg;

`ifndef SYNTHESIS
    a_walk_end_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid |-> state_reg == ST_WALK)
        else $error("chain result outside walk");
    a_no_accept_while_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !accept)
        else $error("word accepted during walk");
    a_grant_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && granted_reg) |-> !legitimate_reg)
        else $error("grant with check flag");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("allocated count overflow");
`endif

endmodule
